FILE: rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared widths, command and status codes for the sample store percentile
// block.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int DEPTH_DEFAULT = 1024;

  localparam int CMD_W    = 2;
  localparam int SAMPLE_W = 32;
  localparam int FRAC_W   = 17;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int STORED_W = 11;

  // Q1.16 fraction: product is rounded half up, then shifted down
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 32768;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

FILE: rtl/ssp_ram.sv
// ----------------------------------------------------------------------------
// ssp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sample_store_percentile.sv
// ----------------------------------------------------------------------------
// sample_store_percentile
// Sorted sample store that answers percentile queries by midpoint of two
// neighboring sorted entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: cmd, sample and
//   fraction. cmd ADD inserts sample in ascending order, QUERY returns the
//   floor mean of sorted entries idx-1 and idx with idx = round(fraction*n)
//   clamped to 1..n-1, CLEAR empties the store. Each request yields exactly
//   one result on the output channel (out_valid/out_ready): value, status
//   and stored count.
//   CLEAR, unused codes, an ADD to a full store and a QUERY on an empty
//   store answer in the cycle after acceptance. An ADD walks down from the
//   top of the store with a RAM read, then a compare and write back, for
//   each larger entry it moves up, and writes the sample where it stops.
//   A QUERY steps through multiply, index clamp, two RAM reads and the add.
//   One request is in flight at a time; in_ready is high only in the idle
//   state with the result register empty or draining.
//   Reset empties the store at once; RAM contents are left as they are,
//   since only entries below the count are ever read.
//   A stalled receiver holds the result register and blocks new requests.
// ----------------------------------------------------------------------------
module sample_store_percentile #(
  parameter int DEPTH = ssp_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ssp_pkg::CMD_W-1:0]     cmd,
  input  logic [ssp_pkg::SAMPLE_W-1:0]  sample,
  input  logic [ssp_pkg::FRAC_W-1:0]    fraction,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ssp_pkg::VALUE_W-1:0]   value,
  output logic [ssp_pkg::STATUS_W-1:0]  status,
  output logic [ssp_pkg::STORED_W-1:0]  stored
);

  import ssp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = FRAC_W + CW;
  localparam int IW = PW + 1 - FRAC_BITS;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_INS_RD  = 8'b0000_0010,
    S_INS_CMP = 8'b0000_0100,
    S_Q_MUL   = 8'b0000_1000,
    S_Q_IDX   = 8'b0001_0000,
    S_Q_RDA   = 8'b0010_0000,
    S_Q_RDB   = 8'b0100_0000,
    S_Q_SUM   = 8'b1000_0000
  } state_t;

  state_t                state;
  logic [CW-1:0]         count;
  logic [AW-1:0]         pos;
  logic [SAMPLE_W-1:0]   sample_r;
  logic [FRAC_W-1:0]     frac_r;
  logic [PW-1:0]         prod;
  logic [AW-1:0]         lo_addr;
  logic [AW-1:0]         hi_addr;
  logic [SAMPLE_W-1:0]   lo_data;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [SAMPLE_W-1:0]   ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [SAMPLE_W-1:0]   ram_rdata;

  logic                  shift_up;
  logic [PW:0]           rounded;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         idx_max;
  logic [SAMPLE_W:0]     pair_sum;
  logic [CW-1:0]         count_inc;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign shift_up  = ram_rdata > sample_r;
  assign count_inc = count + 1'b1;
  assign rounded   = {1'b0, prod} + (PW + 1)'(ROUND_HALF);
  assign idx       = rounded[PW:FRAC_BITS];
  assign idx_max   = IW'(count) - 1'b1;
  assign pair_sum  = {1'b0, lo_data} + {1'b0, ram_rdata};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = sample_r;
    ram_raddr = pos - 1'b1;
    unique case (state)
      S_INS_RD: begin
        ram_we = (pos == '0);
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (shift_up) begin
          ram_wdata = ram_rdata;
        end
      end
      S_Q_RDA: ram_raddr = lo_addr;
      S_Q_RDB: ram_raddr = hi_addr;
      default: ram_raddr = pos - 1'b1;
    endcase
  end

  ssp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            priority if (cmd == CMD_ADD) begin
              if (count == CW'(DEPTH)) begin
                out_valid <= 1'b1;
                value     <= '0;
                status    <= ST_FULL;
                stored    <= STORED_W'(count);
              end else begin
                sample_r <= sample;
                pos      <= AW'(count);
                state    <= S_INS_RD;
              end
            end else if (cmd == CMD_QUERY) begin
              if (count == '0) begin
                out_valid <= 1'b1;
                value     <= '0;
                status    <= ST_EMPTY;
                stored    <= '0;
              end else begin
                frac_r <= fraction;
                state  <= S_Q_MUL;
              end
            end else if (cmd == CMD_CLEAR) begin
              count     <= '0;
              out_valid <= 1'b1;
              value     <= '0;
              status    <= ST_OK;
              stored    <= '0;
            end else begin
              out_valid <= 1'b1;
              value     <= '0;
              status    <= ST_OK;
              stored    <= STORED_W'(count);
            end
          end
        end
        S_INS_RD: begin
          if (pos == '0) begin
            count     <= count_inc;
            out_valid <= 1'b1;
            value     <= '0;
            status    <= ST_OK;
            stored    <= STORED_W'(count_inc);
            state     <= S_IDLE;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (shift_up) begin
            // move the larger entry up, keep walking down
            pos   <= pos - 1'b1;
            state <= S_INS_RD;
          end else begin
            count     <= count_inc;
            out_valid <= 1'b1;
            value     <= '0;
            status    <= ST_OK;
            stored    <= STORED_W'(count_inc);
            state     <= S_IDLE;
          end
        end
        S_Q_MUL: begin
          prod  <= PW'(frac_r) * PW'(count);
          state <= S_Q_IDX;
        end
        S_Q_IDX: begin
          // single sample: read entry zero twice, the mean is the sample
          priority if (count == CW'(1)) begin
            lo_addr <= '0;
            hi_addr <= '0;
          end else if (idx == '0) begin
            lo_addr <= '0;
            hi_addr <= AW'(1);
          end else if (idx > idx_max) begin
            lo_addr <= AW'(idx_max - 1'b1);
            hi_addr <= AW'(idx_max);
          end else begin
            lo_addr <= AW'(idx - 1'b1);
            hi_addr <= AW'(idx);
          end
          state <= S_Q_RDA;
        end
        S_Q_RDA: begin
          state <= S_Q_RDB;
        end
        S_Q_RDB: begin
          lo_data <= ram_rdata;
          state   <= S_Q_SUM;
        end
        S_Q_SUM: begin
          out_valid <= 1'b1;
          value     <= pair_sum[SAMPLE_W:1];
          status    <= ST_OK;
          stored    <= STORED_W'(count);
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/ssp_chk.sv
// ----------------------------------------------------------------------------
// ssp_chk
// Port-level checks for the sample store percentile block, bound to the
// top level.
// ----------------------------------------------------------------------------
module ssp_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [ssp_pkg::CMD_W-1:0]     cmd,
  input logic [ssp_pkg::SAMPLE_W-1:0]  sample,
  input logic [ssp_pkg::FRAC_W-1:0]    fraction,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ssp_pkg::VALUE_W-1:0]   value,
  input logic [ssp_pkg::STATUS_W-1:0]  status,
  input logic [ssp_pkg::STORED_W-1:0]  stored
);

  import ssp_pkg::*;

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // a waiting request holds its payload until taken
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(cmd) && $stable(sample) && $stable(fraction)))
    else $error("waiting request changed");

  // a stalled result holds its value and stored count
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(value) && $stable(stored)))
    else $error("stalled result changed");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (value == '0))
    else $error("dropped sample reported a value");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (value == '0 && stored == '0))
    else $error("empty query with nonzero value or count");

endmodule

bind sample_store_percentile ssp_chk u_ssp_chk (.*);
